@@ rtl/salc_pkg.sv @@
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants for the set-associative LRU cache miss counter.
// ----------------------------------------------------------------------------
package salc_pkg;

    // Default geometry, handed to the top-level parameters.
    localparam int MAX_SETS_DEF       = 64;
    localparam int MAX_WAYS_DEF       = 8;
    localparam int LINE_ADDR_BITS_DEF = 48;

    // Upper limits of the parameter ranges, used for fixed-width fields.
    localparam int WAYS_LIMIT   = 16;
    localparam int RANK_LIMIT_W = 4;
    // Wide enough to hold any way count from 0 to WAYS_LIMIT.
    localparam int WAYS_W       = 5;

    // Configuration register fields.
    localparam int SET_LOG2_W   = 3;
    localparam int WAYS_CFG_W   = 4;
    // Low address bits that can ever take part in the set index.
    localparam int SET_SEL_W    = 7;
    localparam int SET_MAP_SIZE = 1 << SET_SEL_W;

    localparam logic [SET_LOG2_W-1:0] SET_LOG2_RST = 3'd4;
    localparam logic [WAYS_CFG_W-1:0] WAYS_RST     = 4'd4;

    // Configuration bus.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register index, taken from the word address bit.
    typedef enum logic {
        REG_SET_LOG2 = 1'b0,
        REG_WAYS     = 1'b1
    } t_reg_idx;

    // Result of comparing one set against a line address.
    typedef struct packed {
        logic                    hit;
        logic                    evict;
        logic [WAYS_LIMIT-1:0]   hit_mask;
        logic [WAYS_LIMIT-1:0]   victim_mask;
        logic [RANK_LIMIT_W-1:0] hit_rank;
    } t_lookup;

endpackage

@@ rtl/salc_set_ram.sv @@
// ----------------------------------------------------------------------------
// salc_set_ram
// Per-set storage: a tag memory and a valid/rank memory, one row per set,
// with a registered read and a per-row valid flag cleared at reset.
// ----------------------------------------------------------------------------
module salc_set_ram
    import salc_pkg::*;
#(
    parameter int MAX_SETS       = MAX_SETS_DEF,
    parameter int MAX_WAYS       = MAX_WAYS_DEF,
    parameter int LINE_ADDR_BITS = LINE_ADDR_BITS_DEF,
    parameter int SET_W          = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
    parameter int RANK_W         = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_rd_en,
    input  logic [SET_W-1:0]                        i_rd_addr,
    output logic [MAX_WAYS-1:0][LINE_ADDR_BITS-1:0] o_rd_tags,
    output logic [MAX_WAYS-1:0]                     o_rd_valid,
    output logic [MAX_WAYS-1:0][RANK_W-1:0]         o_rd_rank,
    input  logic                                    i_wr_en,
    input  logic [SET_W-1:0]                        i_wr_addr,
    input  logic [MAX_WAYS-1:0][LINE_ADDR_BITS-1:0] i_wr_tags,
    input  logic [MAX_WAYS-1:0]                     i_wr_valid,
    input  logic [MAX_WAYS-1:0][RANK_W-1:0]         i_wr_rank
);

    logic [MAX_WAYS-1:0][LINE_ADDR_BITS-1:0] r_tag_mem [MAX_SETS];
    logic [MAX_WAYS-1:0][RANK_W:0]           r_meta_mem [MAX_SETS];
    logic [MAX_WAYS-1:0][LINE_ADDR_BITS-1:0] r_rd_tags;
    logic [MAX_WAYS-1:0][RANK_W:0]           r_rd_meta;
    logic [MAX_WAYS-1:0][RANK_W:0]           w_wr_meta;
    logic [MAX_SETS-1:0]                     r_row_ok;
    logic                                    r_rd_ok;

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            w_wr_meta[w] = {i_wr_valid[w], i_wr_rank[w]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_tag_mem[i_wr_addr]  <= i_wr_tags;
            r_meta_mem[i_wr_addr] <= w_wr_meta;
        end
        if (i_rd_en) begin
            r_rd_tags <= r_tag_mem[i_rd_addr];
            r_rd_meta <= r_meta_mem[i_rd_addr];
        end
    end

    // A row never written since reset reads as empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_ok[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_row_ok[i_rd_addr];
            end
        end
    end

    always_comb begin
        o_rd_tags = r_rd_tags;
        for (int w = 0; w < MAX_WAYS; w++) begin
            o_rd_valid[w] = r_rd_ok & r_rd_meta[w][RANK_W];
            o_rd_rank[w]  = r_rd_ok ? r_rd_meta[w][RANK_W-1:0] : '0;
        end
    end

endmodule

@@ rtl/salc_lookup.sv @@
// ----------------------------------------------------------------------------
// salc_lookup
// Compares all ways of one set against a line address and picks the hit way
// and, on a miss in a full set, the least recently used victim.
// ----------------------------------------------------------------------------
module salc_lookup
    import salc_pkg::*;
#(
    parameter int MAX_WAYS       = MAX_WAYS_DEF,
    parameter int LINE_ADDR_BITS = LINE_ADDR_BITS_DEF,
    parameter int RANK_W         = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
    input  logic [MAX_WAYS-1:0][LINE_ADDR_BITS-1:0] i_tags,
    input  logic [MAX_WAYS-1:0]                     i_valid,
    input  logic [MAX_WAYS-1:0][RANK_W-1:0]         i_rank,
    input  logic [LINE_ADDR_BITS-1:0]               i_addr,
    input  logic [WAYS_W-1:0]                       i_ways,
    output t_lookup                                 o_lookup
);

    logic [MAX_WAYS-1:0] w_match;
    logic [MAX_WAYS-1:0] w_hit_mask;
    logic [MAX_WAYS-1:0] w_victim;
    logic [RANK_W-1:0]   w_hit_rank;
    logic [RANK_W-1:0]   w_best;
    logic                w_have;
    logic [WAYS_W-1:0]   w_count;

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            w_match[w] = i_valid[w] && (i_tags[w] == i_addr);
        end
    end

    // The lowest matching way wins.
    assign w_hit_mask = w_match & (~w_match + 1'b1);
    assign w_count    = WAYS_W'($countones(i_valid));

    always_comb begin
        w_hit_rank = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (w_hit_mask[w]) begin
                w_hit_rank = i_rank[w];
            end
        end
    end

    // Victim is the valid way with the highest rank; on a tie the lowest way.
    always_comb begin
        w_victim = '0;
        w_best   = '0;
        w_have   = 1'b0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (i_valid[w] && (!w_have || (i_rank[w] > w_best))) begin
                w_victim    = '0;
                w_victim[w] = 1'b1;
                w_best      = i_rank[w];
                w_have      = 1'b1;
            end
        end
    end

    always_comb begin
        o_lookup.hit         = |w_match;
        o_lookup.evict       = !(|w_match) && (w_count >= i_ways);
        o_lookup.hit_mask    = WAYS_LIMIT'(w_hit_mask);
        o_lookup.victim_mask = WAYS_LIMIT'(w_victim);
        o_lookup.hit_rank    = RANK_LIMIT_W'(w_hit_rank);
    end

endmodule

@@ rtl/salc_update.sv @@
// ----------------------------------------------------------------------------
// salc_update
// Builds the new contents of a set after a hit or a miss: recency ranks,
// eviction of the victim and insertion of the new line as most recent.
// ----------------------------------------------------------------------------
module salc_update
    import salc_pkg::*;
#(
    parameter int MAX_WAYS       = MAX_WAYS_DEF,
    parameter int LINE_ADDR_BITS = LINE_ADDR_BITS_DEF,
    parameter int RANK_W         = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
    input  logic [MAX_WAYS-1:0][LINE_ADDR_BITS-1:0] i_tags,
    input  logic [MAX_WAYS-1:0]                     i_valid,
    input  logic [MAX_WAYS-1:0][RANK_W-1:0]         i_rank,
    input  logic [LINE_ADDR_BITS-1:0]               i_addr,
    input  t_lookup                                 i_lookup,
    output logic [MAX_WAYS-1:0][LINE_ADDR_BITS-1:0] o_tags,
    output logic [MAX_WAYS-1:0]                     o_valid,
    output logic [MAX_WAYS-1:0][RANK_W-1:0]         o_rank
);

    logic [MAX_WAYS-1:0] w_hit_mask;
    logic [MAX_WAYS-1:0] w_victim;
    logic [MAX_WAYS-1:0] w_keep;
    logic [MAX_WAYS-1:0] w_free;
    logic [MAX_WAYS-1:0] w_slot;

    assign w_hit_mask = i_lookup.hit_mask[MAX_WAYS-1:0];
    assign w_victim   = i_lookup.evict ? i_lookup.victim_mask[MAX_WAYS-1:0] : '0;
    assign w_keep     = i_valid & ~w_victim;
    assign w_free     = ~w_keep;
    // First free way after the eviction takes the new line.
    assign w_slot     = w_free & (~w_free + 1'b1);

    always_comb begin
        o_tags  = i_tags;
        o_valid = i_valid;
        o_rank  = i_rank;
        if (i_lookup.hit) begin
            for (int w = 0; w < MAX_WAYS; w++) begin
                if (i_valid[w] && (RANK_LIMIT_W'(i_rank[w]) < i_lookup.hit_rank)) begin
                    o_rank[w] = RANK_W'(i_rank[w] + 1'b1);
                end
                if (w_hit_mask[w]) begin
                    o_rank[w] = '0;
                end
            end
        end else begin
            o_valid = w_keep;
            for (int w = 0; w < MAX_WAYS; w++) begin
                if (w_keep[w]) begin
                    o_rank[w] = RANK_W'(i_rank[w] + 1'b1);
                end else if (w_slot[w]) begin
                    o_valid[w] = 1'b1;
                    o_tags[w]  = i_addr;
                    o_rank[w]  = '0;
                end
            end
        end
    end

endmodule

@@ rtl/set_assoc_lru_cache_miss_counter.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_miss_counter
// Set-associative cache tag model with true LRU replacement and a saturating
// miss counter.
// ----------------------------------------------------------------------------
// Usage. Each input transaction carries one cache-line address on the
// valid/stall input channel; each produces exactly one output transaction
// with the hit flag and the running miss total, this access included.
// The set is the low set_count_log2 address bits, folded onto MAX_SETS.
// Every way of the set is compared against the full line address.
//
// Sequencing. A transaction is accepted in the idle state, and its set is read
// from the set memory as it is accepted. The compare result is registered in
// the lookup state; in the update state the output result is registered and
// the updated set written back. The block then returns to idle and only there
// takes a new input transaction, since the read, compare and write-back loop
// runs through the single set memory. Only one address is in flight, so no
// forwarding is required.
// When the receiver stalls, the result stays in the output register and the
// block takes the next address; that one waits in its update step until the
// output register is free.
//
// Reset clears per-set valid flags (each set reads empty), the miss counter
// and output valid, and loads set_count_log2 = 4, ways_in_use = 4. Users must
// write configuration via APB only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_miss_counter
    import salc_pkg::*;
#(
    parameter int MAX_SETS       = MAX_SETS_DEF,
    parameter int MAX_WAYS       = MAX_WAYS_DEF,
    parameter int LINE_ADDR_BITS = LINE_ADDR_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready,
    // Address channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [LINE_ADDR_BITS-1:0] i_line_address,
    // Result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_hit,
    output logic [31:0]               o_miss_count
);

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_LOOKUP = 3'b010,
        S_UPDATE = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Configuration registers
    logic [SET_LOG2_W-1:0] r_set_log2;
    logic [WAYS_CFG_W-1:0] r_ways_cfg;
    logic                  w_cfg_wr;
    t_reg_idx              w_reg_idx;

    // Transaction in flight
    logic [LINE_ADDR_BITS-1:0] r_addr;
    logic [SET_W-1:0]          r_set;
    logic [WAYS_W-1:0]         r_ways;
    t_lookup                   r_lkp;
    t_lookup                   w_lkp;

    // Set index formation
    logic [SET_W-1:0]     w_set_map [SET_MAP_SIZE];
    logic [SET_SEL_W-1:0] w_low_mask;
    logic [SET_SEL_W-1:0] w_low;
    logic [SET_W-1:0]     w_set;
    logic [WAYS_W-1:0]    w_ways_eff;

    // Set memory ports
    logic [MAX_WAYS-1:0][LINE_ADDR_BITS-1:0] w_rd_tags, w_wr_tags;
    logic [MAX_WAYS-1:0]                     w_rd_valid, w_wr_valid;
    logic [MAX_WAYS-1:0][RANK_W-1:0]         w_rd_rank, w_wr_rank;

    // Handshakes and counter
    logic        w_in_acc;
    logic        w_out_acc;
    logic        w_done;
    logic [31:0] r_miss_total, n_miss_total;
    logic        r_out_valid;
    logic        r_out_hit;
    logic [31:0] r_out_miss;

    // ------------------------------------------------------------------
    // Configuration port. The word address bit selects the register; a
    // write lands in the access phase. Reads return the stored value.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_log2 <= SET_LOG2_RST;
            r_ways_cfg <= WAYS_RST;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_SET_LOG2: r_set_log2 <= pwdata[SET_LOG2_W-1:0];
                REG_WAYS:     r_ways_cfg <= pwdata[WAYS_CFG_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_SET_LOG2: prdata = PDATA_W'(r_set_log2);
            REG_WAYS:     prdata = PDATA_W'(r_ways_cfg);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Set index: the low set_count_log2 bits, folded onto MAX_SETS through
    // a table worked out at elaboration, so any set count is handled.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < SET_MAP_SIZE; g++) begin : g_set_map
        assign w_set_map[g] = SET_W'(g % MAX_SETS);
    end

    assign w_low_mask = SET_SEL_W'((8'd1 << r_set_log2) - 8'd1);
    assign w_low      = i_line_address[SET_SEL_W-1:0] & w_low_mask;
    assign w_set      = w_set_map[w_low];

    // A way count of zero behaves as one; above MAX_WAYS it is clipped.
    always_comb begin
        if (r_ways_cfg == '0) begin
            w_ways_eff = WAYS_W'(1);
        end else if (WAYS_W'(r_ways_cfg) > WAYS_W'(MAX_WAYS)) begin
            w_ways_eff = WAYS_W'(MAX_WAYS);
        end else begin
            w_ways_eff = WAYS_W'(r_ways_cfg);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: accept and read, compare, then write back and report.
    // ------------------------------------------------------------------
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_acc  = r_out_valid && !i_out_stall;
    assign w_done     = (r_state == S_UPDATE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        case (r_state)
            S_IDLE:   n_state = w_in_acc ? S_LOOKUP : S_IDLE;
            S_LOOKUP: n_state = S_UPDATE;
            S_UPDATE: n_state = w_done ? S_IDLE : S_UPDATE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_addr <= i_line_address;
            r_set  <= w_set;
            r_ways <= w_ways_eff;
        end
        if (r_state == S_LOOKUP) begin
            r_lkp <= w_lkp;
        end
    end

    salc_set_ram #(
        .MAX_SETS       (MAX_SETS),
        .MAX_WAYS       (MAX_WAYS),
        .LINE_ADDR_BITS (LINE_ADDR_BITS),
        .SET_W          (SET_W),
        .RANK_W         (RANK_W)
    ) u_set_ram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_in_acc),
        .i_rd_addr  (w_set),
        .o_rd_tags  (w_rd_tags),
        .o_rd_valid (w_rd_valid),
        .o_rd_rank  (w_rd_rank),
        .i_wr_en    (w_done),
        .i_wr_addr  (r_set),
        .i_wr_tags  (w_wr_tags),
        .i_wr_valid (w_wr_valid),
        .i_wr_rank  (w_wr_rank)
    );

    salc_lookup #(
        .MAX_WAYS       (MAX_WAYS),
        .LINE_ADDR_BITS (LINE_ADDR_BITS),
        .RANK_W         (RANK_W)
    ) u_lookup (
        .i_tags   (w_rd_tags),
        .i_valid  (w_rd_valid),
        .i_rank   (w_rd_rank),
        .i_addr   (r_addr),
        .i_ways   (r_ways),
        .o_lookup (w_lkp)
    );

    // The read data stays put until the next acceptance, so the update
    // step works on the same set image that was compared.
    salc_update #(
        .MAX_WAYS       (MAX_WAYS),
        .LINE_ADDR_BITS (LINE_ADDR_BITS),
        .RANK_W         (RANK_W)
    ) u_update (
        .i_tags   (w_rd_tags),
        .i_valid  (w_rd_valid),
        .i_rank   (w_rd_rank),
        .i_addr   (r_addr),
        .i_lookup (r_lkp),
        .o_tags   (w_wr_tags),
        .o_valid  (w_wr_valid),
        .o_rank   (w_wr_rank)
    );

    // ------------------------------------------------------------------
    // Miss counter, saturating at all ones, and the output register.
    // ------------------------------------------------------------------
    always_comb begin
        n_miss_total = r_miss_total;
        if (!r_lkp.hit && !(&r_miss_total)) begin
            n_miss_total = r_miss_total + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss_total <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_done) begin
                r_miss_total <= n_miss_total;
                r_out_valid  <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_hit  <= r_lkp.hit;
            r_out_miss <= n_miss_total;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_miss_count = r_out_miss;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An accepted address is compared and then reaches the update step.
    a_seq_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_LOOKUP) ##1 (r_state == S_UPDATE))
        else $error("accepted transaction did not progress to lookup and update");

    // The miss total never goes backwards.
    a_miss_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_miss_total >= $past(r_miss_total)))
        else $error("miss total decreased");

    // A hit leaves the miss total alone.
    a_hit_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && r_lkp.hit) |=> (r_miss_total == $past(r_miss_total)))
        else $error("miss total changed on a hit");

    // At most one hit way, and the hit flag agrees with it; a hit never evicts.
    a_hit_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |-> ($onehot0(r_lkp.hit_mask)
            && (r_lkp.hit == (r_lkp.hit_mask != '0))
            && !(r_lkp.hit && r_lkp.evict)))
        else $error("inconsistent lookup result");

endmodule

@@ dv/salc_outcome_pkg.sv @@
// ----------------------------------------------------------------------------
// salc_outcome_pkg
// Tracks expected cache outcomes for the set-associative LRU miss counter.
// A shadow copy of the tag store, the recency ranks and the miss counter is
// kept here. Every accepted line address is looked up in that copy, and the
// predicted hit flag and miss total are queued for checking.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package salc_outcome_pkg;

    import salc_pkg::*;

    localparam int ADDR_W = LINE_ADDR_BITS_DEF;
    localparam int SETS   = MAX_SETS_DEF;
    localparam int WAYS   = MAX_WAYS_DEF;

    typedef struct {
        logic        hit;
        logic [31:0] miss_count;
    } t_outcome;

    class cache_outcome_board;

        logic [ADDR_W-1:0]     tag_store [SETS][WAYS];
        bit                    line_held [SETS][WAYS];
        int                    age_rank  [SETS][WAYS];
        logic [31:0]           misses;
        logic [SET_LOG2_W-1:0] set_log2;
        logic [WAYS_CFG_W-1:0] ways_cfg;
        t_outcome              outcome_queue [$];
        int                    failures;

        function new();
            foreach (line_held[s, w]) begin
                tag_store[s][w] = '0;
                line_held[s][w] = 1'b0;
                age_rank[s][w]  = 0;
            end
            misses   = '0;
            set_log2 = SET_LOG2_RST;
            ways_cfg = WAYS_RST;
            failures = 0;
        endfunction

        function void set_config(t_reg_idx idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_SET_LOG2: set_log2 = value[SET_LOG2_W-1:0];
                REG_WAYS:     ways_cfg = value[WAYS_CFG_W-1:0];
                default:      ;
            endcase
        endfunction

        // Looks the line up in the shadow store, applies the LRU update and
        // queues the outcome that the block must report for it.
        function void note_access(logic [ADDR_W-1:0] line);
            bit [63:0] low_bits;
            int        s;
            int        ways;
            int        held;
            int        found;
            int        rank;
            int        victim;
            int        top;
            int        slot;
            t_outcome  outcome;

            low_bits = 64'(line) & ((64'd1 << set_log2) - 64'd1);
            s        = int'(low_bits % SETS);
            ways     = int'(ways_cfg);
            if (ways < 1) ways = 1;
            if (ways > WAYS) ways = WAYS;

            held  = 0;
            found = -1;
            for (int w = 0; w < WAYS; w++) begin
                if (line_held[s][w]) begin
                    held++;
                    if (found < 0 && tag_store[s][w] == line) found = w;
                end
            end

            if (found >= 0) begin
                rank = age_rank[s][found];
                for (int w = 0; w < WAYS; w++) begin
                    if (line_held[s][w] && age_rank[s][w] < rank) age_rank[s][w]++;
                end
                age_rank[s][found] = 0;
                outcome.hit = 1'b1;
            end else begin
                if (misses != 32'hFFFF_FFFF) misses++;
                // Only the single oldest line goes, even if the set is over-full.
                if (held >= ways) begin
                    victim = 0;
                    top    = -1;
                    for (int w = 0; w < WAYS; w++) begin
                        if (line_held[s][w] && age_rank[s][w] > top) begin
                            top    = age_rank[s][w];
                            victim = w;
                        end
                    end
                    line_held[s][victim] = 1'b0;
                end
                slot = -1;
                for (int w = 0; w < WAYS; w++) begin
                    if (line_held[s][w]) age_rank[s][w]++;
                    else if (slot < 0) slot = w;
                end
                if (slot >= 0) begin
                    line_held[s][slot] = 1'b1;
                    tag_store[s][slot] = line;
                    age_rank[s][slot]  = 0;
                end
                outcome.hit = 1'b0;
            end
            outcome.miss_count = misses;
            outcome_queue.push_back(outcome);
        endfunction

        function void check_outcome(logic hit, logic [31:0] miss_count);
            t_outcome want;
            if (outcome_queue.size() == 0) begin
                $error("result transaction with no access outstanding: hit %0d miss_count %0d",
                       hit, miss_count);
                failures++;
                return;
            end
            want = outcome_queue.pop_front();
            if (hit !== want.hit) begin
                $error("hit: expected %0d, actual %0d", want.hit, hit);
                failures++;
            end
            if (miss_count !== want.miss_count) begin
                $error("miss_count: expected %0d, actual %0d", want.miss_count, miss_count);
                failures++;
            end
        endfunction

        function int pending();
            return outcome_queue.size();
        endfunction

    endclass

endpackage

@@ dv/set_assoc_lru_cache_miss_counter_test.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_miss_counter_test
// Self-checking test of the set-associative LRU cache miss counter.
// A directed sequence covers the address extremes, eviction order and the
// corner cases of the geometry registers; random phases then replay address
// pools of varying size and set crowding under changing configurations, with
// random idle cycles on both channels. Every result transaction is compared
// with a shadow model of the cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module set_assoc_lru_cache_miss_counter_test;

    import salc_pkg::*;
    import salc_outcome_pkg::*;

    localparam int PHASES     = 10;
    localparam int PHASE_ITEMS = 95;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [ADDR_W-1:0]    i_line_address = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_hit;
    logic [31:0]          o_miss_count;

    // When set, the sender or the receiver runs without idle cycles, so that
    // back-to-back transactions are exercised as well as sparse ones.
    bit                   tx_quiet = 1'b0;
    bit                   rx_quiet = 1'b0;

    cache_outcome_board   board = new();
    logic [ADDR_W-1:0]    line_pool [$];

    set_assoc_lru_cache_miss_counter i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_line_address (i_line_address),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hit          (o_hit),
        .o_miss_count   (o_miss_count)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Fully random line address; every bit of the field is free.
    function automatic logic [ADDR_W-1:0] random_line();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[ADDR_W-1:0];
    endfunction

    // Presents one address transaction after a random number of idle cycles
    // and returns at the edge at which it is accepted. If no idle cycles are
    // drawn, valid simply stays high and the payload moves on.
    task automatic send_access(input logic [ADDR_W-1:0] line);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_line_address <= line;
        do @(posedge i_clk); while (o_in_stall);
        board.note_access(line);
    endtask

    // One APB write: a setup cycle, then an access cycle that completes at
    // the edge where pready is seen high. The bus is left idle afterwards, so
    // that consecutive writes never collide on psel.
    task automatic reg_write(input t_reg_idx idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_config(idx, value);
        @(posedge i_clk);
    endtask

    // Lets the block drain completely before the geometry is touched. The
    // upper data bits carry noise, which the registers must ignore.
    task automatic reconfigure(input logic [SET_LOG2_W-1:0] set_log2,
                               input logic [WAYS_CFG_W-1:0] ways,
                               input bit write_sets, input bit write_ways);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
        repeat (4) @(posedge i_clk);
        if (write_sets) begin
            reg_write(REG_SET_LOG2, ($urandom & ~32'h7) | 32'(set_log2));
        end
        if (write_ways) begin
            reg_write(REG_WAYS, ($urandom & ~32'hF) | 32'(ways));
        end
    endtask

    // A random phase draws most addresses from a small pool, so that lines
    // are revisited and the LRU order matters. With crowding, the pool
    // collapses onto a handful of sets and forces evictions; the rest of the
    // traffic is fully random noise.
    task automatic run_random_phase(input int items);
        int pool_size;
        bit crowd;
        logic [ADDR_W-1:0] entry;
        pool_size = $urandom_range(2, 48);
        crowd     = 1'($urandom_range(0, 1));
        line_pool.delete();
        for (int i = 0; i < pool_size; i++) begin
            entry = random_line();
            if (crowd) entry[5:0] = 6'($urandom_range(0, 3));
            line_pool.push_back(entry);
        end
        for (int i = 0; i < items; i++) begin
            if ($urandom_range(0, 9) < 8) begin
                send_access(line_pool[$urandom_range(0, pool_size - 1)]);
            end else begin
                send_access(random_line());
            end
        end
    endtask

    // The receiver stalls for a random number of cycles before taking each
    // result transaction, independently of whether one is waiting.
    initial begin
        int hold;
        repeat (10) @(posedge i_clk);
        forever begin
            hold = rx_quiet ? 0 : $urandom_range(0, 13);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
            board.check_outcome(o_hit, o_miss_count);
        end
    end

    initial begin
        logic [SET_LOG2_W-1:0] set_log2;
        logic [WAYS_CFG_W-1:0] ways;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset geometry of sixteen sets by four ways. The extreme addresses
        // land in sets zero and fifteen; set zero is then filled, its oldest
        // line refreshed, and the next miss must evict the second oldest.
        send_access('0);
        send_access('1);
        send_access('1);
        send_access(ADDR_W'(16));
        send_access(ADDR_W'(32));
        send_access(ADDR_W'(48));
        send_access('0);
        send_access(ADDR_W'(64));
        send_access(ADDR_W'(16));

        // 128 sets fold onto 64, and a way count of zero behaves as one. The
        // all-ones line now indexes a different set, so it misses.
        reconfigure(3'd7, 4'd0, 1'b1, 1'b1);
        send_access('1);
        send_access('0);
        send_access(ADDR_W'(64));
        send_access('0);

        // One set with the way count above the maximum: eight lines fit.
        // Reducing the ways to two then removes just one line per miss.
        reconfigure(3'd0, 4'd15, 1'b1, 1'b1);
        for (int i = 1; i <= 8; i++) begin
            send_access(ADDR_W'(i));
        end
        reconfigure(3'd0, 4'd2, 1'b0, 1'b1);
        send_access(ADDR_W'(9));
        send_access(ADDR_W'(2));

        // Random phases. The first ones pin the geometry at its extremes,
        // two others change only one register while lines are still held.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       begin set_log2 = 3'd0; ways = 4'd1; end
                1:       begin set_log2 = 3'd6; ways = 4'd8; end
                2:       begin set_log2 = 3'd7; ways = 4'd8; end
                3:       begin set_log2 = 3'd1; ways = 4'd0; end
                4:       begin set_log2 = 3'd3; ways = 4'd15; end
                default: begin
                    set_log2 = 3'($urandom_range(0, 7));
                    ways     = 4'($urandom_range(0, 15));
                end
            endcase
            reconfigure(set_log2, ways, p != 6, p != 7);
            tx_quiet = (p % 3 == 1);
            rx_quiet = (p % 3 == 2);
            run_random_phase(PHASE_ITEMS);
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
        repeat (10) @(posedge i_clk);
        if (board.failures == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Safety net for a hung handshake: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
